/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent checks on the clk/rst domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, status codes and pipeline types shared by the solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_W    = 34;
  localparam int DISC_W    = 2 * COEF_W + 2;     // b*b - 4ac, signed
  localparam int SQRT_W    = DISC_W / 2;         // floor sqrt result bits
  localparam int DEN_W     = COEF_W + 1;         // 2a, signed
  localparam int NUM_W     = SQRT_W + 2;         // -b +/- s, signed
  localparam int DIV_N_W   = ROOT_W;             // scaled numerator magnitude
  localparam int DIV_D_W   = DEN_W;              // divisor magnitude
  localparam int FRONT_LAT = 3;
  localparam int PIPE_LAT  = FRONT_LAT + SQRT_W + 1 + DIV_N_W + 1;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ONE  = 2'd1,
    ST_TWO  = 2'd2,
    ST_NOTQ = 2'd3
  } qrs_status_t;

  // Side data carried alongside the square root
  typedef struct packed {
    qrs_status_t              status;
    logic signed [COEF_W-1:0] b;
    logic signed [DEN_W-1:0]  den;
  } qrs_tag_t;

  // Side data carried alongside each divider
  typedef struct packed {
    qrs_status_t status;
    logic        neg;
  } qrs_dtag_t;

endpackage

/* rtl/qrs_front.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver front end
// Registers the coefficients, forms the products and the discriminant.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic signed [qrs_pkg::COEF_W-1:0] a,
  input  logic signed [qrs_pkg::COEF_W-1:0] b,
  input  logic signed [qrs_pkg::COEF_W-1:0] c,
  output logic                              out_vld,
  output logic        [qrs_pkg::DISC_W-1:0] rad,
  output qrs_pkg::qrs_tag_t                 tag
);
  import qrs_pkg::*;

  logic                       vld1, vld2;
  logic signed [COEF_W-1:0]   a1, b1, c1, a2, b2;
  logic signed [2*COEF_W-1:0] bb2, ac2;
  logic signed [DISC_W-1:0]   disc;
  qrs_status_t                status_next;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  // Capture coefficients, then the two products
  always_ff @(posedge clk) begin
    a1  <= a;
    b1  <= b;
    c1  <= c;
    a2  <= a1;
    b2  <= b1;
    bb2 <= b1 * b1;
    ac2 <= a1 * c1;
  end

  // Classify the discriminant
  always_comb begin
    disc = DISC_W'(bb2) - (DISC_W'(ac2) <<< 2);
    if (a2 == '0) begin
      status_next = ST_NOTQ;
    end else if (disc < 0) begin
      status_next = ST_NONE;
    end else if (disc == '0) begin
      status_next = ST_ONE;
    end else begin
      status_next = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    rad        <= disc[DISC_W-1] ? '0 : disc;
    tag.status <= status_next;
    tag.b      <= b2;
    tag.den    <= DEN_W'(a2) <<< 1;
  end

endmodule

/* rtl/qrs_sqrt.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver square root
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [qrs_pkg::DISC_W-1:0] in_rad,
  input  qrs_pkg::qrs_tag_t          in_tag,
  output logic                       out_vld,
  output logic [qrs_pkg::SQRT_W-1:0] out_root,
  output qrs_pkg::qrs_tag_t          out_tag
);
  import qrs_pkg::*;

  localparam int REM_W = SQRT_W + 2;

  logic              vld  [0:SQRT_W];
  logic [DISC_W-1:0] rads [0:SQRT_W];
  logic [REM_W-1:0]  rems [0:SQRT_W];
  logic [SQRT_W-1:0] roots[0:SQRT_W];
  qrs_tag_t          tags [0:SQRT_W];

  assign vld[0]   = in_vld;
  assign rads[0]  = in_rad;
  assign rems[0]  = '0;
  assign roots[0] = '0;
  assign tags[0]  = in_tag;

  for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             take;

    // Bring down the next bit pair and try the new root bit
    always_comb begin
      cur   = {rems[k], rads[k][DISC_W-1 -: 2]};
      trial = (REM_W+2)'({roots[k], 2'b01});
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rads[k+1]  <= rads[k] << 2;
      rems[k+1]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
      roots[k+1] <= {roots[k][SQRT_W-2:0], take};
      tags[k+1]  <= tags[k];
    end
  end

  assign out_vld  = vld[SQRT_W];
  assign out_root = roots[SQRT_W];
  assign out_tag  = tags[SQRT_W];

endmodule

/* rtl/qrs_divider.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [qrs_pkg::DIV_N_W-1:0] in_num,
  input  logic [qrs_pkg::DIV_D_W-1:0] in_den,
  input  qrs_pkg::qrs_dtag_t          in_tag,
  output logic                        out_vld,
  output logic [qrs_pkg::DIV_N_W-1:0] out_quo,
  output qrs_pkg::qrs_dtag_t          out_tag
);
  import qrs_pkg::*;

  logic               vld [0:DIV_N_W];
  logic [DIV_N_W-1:0] sh  [0:DIV_N_W];
  logic [DIV_D_W-1:0] rem [0:DIV_N_W];
  logic [DIV_D_W-1:0] dv  [0:DIV_N_W];
  qrs_dtag_t          tags[0:DIV_N_W];

  assign vld[0]  = in_vld;
  assign sh[0]   = in_num;
  assign rem[0]  = '0;
  assign dv[0]   = in_den;
  assign tags[0] = in_tag;

  for (genvar k = 0; k < DIV_N_W; k++) begin : g_stage
    logic [DIV_D_W:0] cur;
    logic             take;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
      cur  = {rem[k], sh[k][DIV_N_W-1]};
      take = (cur >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= take ? DIV_D_W'(cur - {1'b0, dv[k]}) : DIV_D_W'(cur);
      sh[k+1]   <= {sh[k][DIV_N_W-2:0], take};
      dv[k+1]   <= dv[k];
      tags[k+1] <= tags[k];
    end
  end

  assign out_vld = vld[DIV_N_W];
  assign out_quo = sh[DIV_N_W];
  assign out_tag = tags[DIV_N_W];

endmodule

/* rtl/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c in signed fixed point, 16 fraction bits.
// ----------------------------------------------------------------------------
// Channel   Handshake        Signals
// command   start / busy     coef_a, coef_b, coef_c
// result    done (strobe)    root_status, first_root, second_root
//
// A new transaction may start every cycle; busy is always low.
// Each result passes in order through the product and discriminant
// registers, the square root stages, the numerator register, the
// divider stages and the output register.
// Reset clears all valid bits; results are never held back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_root_solver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                              done,
  output logic        [1:0]                 root_status,
  output logic signed [qrs_pkg::ROOT_W-1:0] first_root,
  output logic signed [qrs_pkg::ROOT_W-1:0] second_root
);
  import qrs_pkg::*;

  logic              f_vld;
  logic [DISC_W-1:0] f_rad;
  qrs_tag_t          f_tag;

  logic              s_vld;
  logic [SQRT_W-1:0] s_root;
  qrs_tag_t          s_tag;

  logic               p_vld;
  logic [DIV_N_W-1:0] p_num1, p_num2;
  logic [DIV_D_W-1:0] p_den;
  qrs_dtag_t          p_tag1, p_tag2;

  logic               d1_vld, d2_vld;
  logic [DIV_N_W-1:0] d1_quo, d2_quo;
  qrs_dtag_t          d1_tag, d2_tag;

  logic signed [NUM_W-1:0] n1, n2;
  logic [NUM_W-1:0]        m1, m2;
  logic [DIV_D_W-1:0]      dmag;
  logic signed [ROOT_W-1:0] r1, r2;
  logic                    has_roots;

  assign busy = 1'b0;

  qrs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start),
    .a       (coef_a),
    .b       (coef_b),
    .c       (coef_c),
    .out_vld (f_vld),
    .rad     (f_rad),
    .tag     (f_tag)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_rad   (f_rad),
    .in_tag   (f_tag),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_tag  (s_tag)
  );

  // Form signed numerators and split into sign and magnitude
  always_comb begin
    n1   = -NUM_W'(s_tag.b) + NUM_W'({1'b0, s_root});
    n2   = -NUM_W'(s_tag.b) - NUM_W'({1'b0, s_root});
    m1   = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    m2   = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    dmag = s_tag.den[DEN_W-1] ? DIV_D_W'(-s_tag.den) : DIV_D_W'(s_tag.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_num1        <= DIV_N_W'(m1) << FRAC_BITS;
    p_num2        <= DIV_N_W'(m2) << FRAC_BITS;
    p_den         <= dmag;
    p_tag1.status <= s_tag.status;
    p_tag1.neg    <= n1[NUM_W-1] ^ s_tag.den[DEN_W-1];
    p_tag2.status <= s_tag.status;
    p_tag2.neg    <= n2[NUM_W-1] ^ s_tag.den[DEN_W-1];
  end

  qrs_divider u_div_first (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p_vld),
    .in_num  (p_num1),
    .in_den  (p_den),
    .in_tag  (p_tag1),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_tag (d1_tag)
  );

  qrs_divider u_div_second (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p_vld),
    .in_num  (p_num2),
    .in_den  (p_den),
    .in_tag  (p_tag2),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_tag (d2_tag)
  );

  // Apply signs and drop roots that do not exist
  always_comb begin
    has_roots = (d1_tag.status == ST_ONE) || (d1_tag.status == ST_TWO);
    r1 = d1_tag.neg ? -$signed(d1_quo) : $signed(d1_quo);
    r2 = d2_tag.neg ? -$signed(d2_quo) : $signed(d2_quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d1_vld & d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    root_status <= d1_tag.status;
    first_root  <= has_roots ? r1 : '0;
    second_root <= has_roots ? r2 : '0;
  end

  `QRS_ASSERT(a_latency, start |-> ##PIPE_LAT done, "result strobe missing after start")
  `QRS_ASSERT(a_div_lockstep, (d1_vld == d2_vld) && (!d1_vld || d1_tag.status == d2_tag.status), "dividers out of step")
  `QRS_ASSERT_NEXT(a_one_root, d1_vld && d1_tag.status == ST_ONE, first_root == second_root, "single root differs")
  `QRS_ASSERT_NEXT(a_no_root, d1_vld && !has_roots, first_root == '0 && second_root == '0, "roots not cleared")

endmodule
